/* hdl/dip_rrip_replacement_defines.svh */
// Assertion macros shared by the RRIP/DIP replacement RTL.
`ifndef DIP_RRIP_REPLACEMENT_DEFINES_SVH
`define DIP_RRIP_REPLACEMENT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define DIPRRIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DIPRRIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/diprrip_pkg.sv */
package diprrip_pkg;

  localparam int SET_W    = 11;
  localparam int WAY_W    = 4;
  localparam int NUM_SETS = 1 << SET_W;
  localparam int NUM_WAYS = 1 << WAY_W;
  localparam int RRPV_W   = 2;
  localparam int ROW_W    = NUM_WAYS * RRPV_W;
  localparam int SEL_W    = 10;
  localparam int ACC_W    = 10;
  localparam int THR_W    = 4;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;

  localparam logic [RRPV_W-1:0] RRPV_TOP = '1;
  localparam logic [ROW_W-1:0]  ROW_ALL_MAX = {NUM_WAYS{RRPV_TOP}};
  localparam logic [SEL_W-1:0]  SEL_MAX = '1;
  localparam logic [SEL_W-1:0]  SEL_MID = SEL_MAX >> 1;
  localparam logic [THR_W-1:0]  THR_RESET = 4'd5;
  localparam logic [THR_W-1:0]  THR_SAT = THR_W'(ACC_W);

  // leader placement: LIP set (i*37) % sets, BIP set (i*71 + 13) % sets
  localparam int LIP_MULT         = 37;
  localparam int BIP_MULT         = 71;
  localparam int BIP_OFFSET       = 13;
  localparam int LEADER_COUNT_DEF = 32;

  typedef enum logic [1:0] {
    ROLE_FOLLOW = 2'd0,
    ROLE_LIP    = 2'd1,
    ROLE_BIP    = 2'd2
  } role_t;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WORK,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    INIT_CLEAR,
    INIT_LEAD,
    INIT_DONE
  } init_state_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] addr;
    logic [ROW_W-1:0] row;
  } mem_wr_t;

endpackage

/* hdl/diprrip_store.sv */
module diprrip_store #(
  parameter int LEADER_COUNT = diprrip_pkg::LEADER_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  diprrip_pkg::mem_rd_t            rd,
  input  diprrip_pkg::mem_wr_t            wr,
  output logic [diprrip_pkg::ROW_W-1:0]   rd_row,
  output diprrip_pkg::role_t              rd_role,
  output logic                            init_done
);

  localparam int IW = (LEADER_COUNT > 1) ? $clog2(LEADER_COUNT) : 1;
  localparam int A_START = ((LEADER_COUNT - 1) * diprrip_pkg::LIP_MULT)
                           % diprrip_pkg::NUM_SETS;
  localparam int B_START = ((LEADER_COUNT - 1) * diprrip_pkg::BIP_MULT
                            + diprrip_pkg::BIP_OFFSET) % diprrip_pkg::NUM_SETS;
  localparam int A_STEP = diprrip_pkg::LIP_MULT % diprrip_pkg::NUM_SETS;
  localparam int B_STEP = diprrip_pkg::BIP_MULT % diprrip_pkg::NUM_SETS;

  logic [diprrip_pkg::ROW_W-1:0] row_mem [diprrip_pkg::NUM_SETS];
  diprrip_pkg::role_t            role_mem [diprrip_pkg::NUM_SETS];

  diprrip_pkg::init_state_t      init_state, init_state_next;
  logic [diprrip_pkg::SET_W-1:0] clr_addr, clr_addr_next;
  logic [IW-1:0]                 lead_i, lead_i_next;
  logic                          lead_phase, lead_phase_next;
  logic [diprrip_pkg::SET_W-1:0] a_addr, a_addr_next;
  logic [diprrip_pkg::SET_W-1:0] b_addr, b_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_state <= diprrip_pkg::INIT_CLEAR;
      clr_addr   <= '0;
      lead_i     <= IW'(LEADER_COUNT - 1);
      lead_phase <= 1'b0;
      a_addr     <= diprrip_pkg::SET_W'(A_START);
      b_addr     <= diprrip_pkg::SET_W'(B_START);
    end else begin
      init_state <= init_state_next;
      clr_addr   <= clr_addr_next;
      lead_i     <= lead_i_next;
      lead_phase <= lead_phase_next;
      a_addr     <= a_addr_next;
      b_addr     <= b_addr_next;
    end
  end

  // Leaders are placed in reverse order so the earliest claim of a set
  // lands last and wins.
  always_comb begin
    init_state_next = init_state;
    clr_addr_next   = clr_addr;
    lead_i_next     = lead_i;
    lead_phase_next = lead_phase;
    a_addr_next     = a_addr;
    b_addr_next     = b_addr;
    case (init_state)
      diprrip_pkg::INIT_CLEAR: begin
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == diprrip_pkg::SET_W'(diprrip_pkg::NUM_SETS - 1)) begin
          init_state_next = diprrip_pkg::INIT_LEAD;
        end
      end
      diprrip_pkg::INIT_LEAD: begin
        lead_phase_next = !lead_phase;
        if (lead_phase) begin
          if (lead_i == '0) begin
            init_state_next = diprrip_pkg::INIT_DONE;
          end else begin
            lead_i_next = lead_i - 1'b1;
            a_addr_next = a_addr - diprrip_pkg::SET_W'(A_STEP);
            b_addr_next = b_addr - diprrip_pkg::SET_W'(B_STEP);
          end
        end
      end
      diprrip_pkg::INIT_DONE: begin
      end
      default: begin
        init_state_next = diprrip_pkg::INIT_CLEAR;
      end
    endcase
  end

  assign init_done = (init_state == diprrip_pkg::INIT_DONE);

  always_ff @(posedge clk) begin
    case (init_state)
      diprrip_pkg::INIT_CLEAR: begin
        row_mem[clr_addr]  <= diprrip_pkg::ROW_ALL_MAX;
        role_mem[clr_addr] <= diprrip_pkg::ROLE_FOLLOW;
      end
      diprrip_pkg::INIT_LEAD: begin
        if (lead_phase) begin
          role_mem[a_addr] <= diprrip_pkg::ROLE_LIP;
        end else begin
          role_mem[b_addr] <= diprrip_pkg::ROLE_BIP;
        end
      end
      default: begin
        if (wr.en) begin
          row_mem[wr.addr] <= wr.row;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_row  <= row_mem[rd.addr];
      rd_role <= role_mem[rd.addr];
    end
  end

endmodule

/* hdl/dip_rrip_replacement.sv */
// One item at a time: s_tready is high only in the idle state, so a new item is taken
// only after the last result is handed to the output register. A victim search ages
// the set row in the work state until a way is at max (up to three rounds), then
// writes the row back when it aged. Reset: line values, leader roles and selector
// are rebuilt; s_tready stays low while the row and role memories are swept.
`include "dip_rrip_replacement_defines.svh"

module dip_rrip_replacement #(
  parameter int LEADER_COUNT = diprrip_pkg::LEADER_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config: bip_throttle_log2
  input  logic                              cfg_we,
  input  logic [diprrip_pkg::THR_W-1:0]     cfg_wdata,
  // s_tdata: set_index[10:0], way_index[14:11], was_hit[15]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [diprrip_pkg::IN_W-1:0]      s_tdata,
  // s_tuser: opcode
  input  logic                              s_tuser,
  // m_tdata: victim_way[3:0], inserted_value[5:4], selector_value[15:6]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [diprrip_pkg::OUT_W-1:0]     m_tdata
);

  localparam int SET_W  = diprrip_pkg::SET_W;
  localparam int WAY_W  = diprrip_pkg::WAY_W;
  localparam int RRPV_W = diprrip_pkg::RRPV_W;
  localparam int ROW_W  = diprrip_pkg::ROW_W;
  localparam int SEL_W  = diprrip_pkg::SEL_W;
  localparam int ACC_W  = diprrip_pkg::ACC_W;

  diprrip_pkg::state_t   state, state_next;
  diprrip_pkg::op_t      op_r, op_r_next;
  logic [SET_W-1:0]      set_r, set_r_next;
  logic [WAY_W-1:0]      way_r, way_r_next;
  logic                  hit_r, hit_r_next;
  diprrip_pkg::role_t    role_r, role_r_next;
  logic [ROW_W-1:0]      row, row_next;
  logic                  aged, aged_next;
  logic [WAY_W-1:0]      victim, victim_next;
  logic [RRPV_W-1:0]     ins, ins_next;
  logic [SEL_W-1:0]      policy_selector, policy_selector_next;
  logic [ACC_W-1:0]      access_count, access_count_next;
  logic [diprrip_pkg::THR_W-1:0] bip_throttle_log2;
  logic                  m_tvalid_next;
  logic [diprrip_pkg::OUT_W-1:0] m_tdata_next;

  diprrip_pkg::mem_rd_t  rd;
  diprrip_pkg::mem_wr_t  wr;
  logic [ROW_W-1:0]      rd_row;
  diprrip_pkg::role_t    rd_role;
  logic                  init_done;

  logic                  found;
  logic [WAY_W-1:0]      first_way;
  logic [ROW_W-1:0]      row_aged;

  diprrip_store #(
    .LEADER_COUNT(LEADER_COUNT)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .rd_row   (rd_row),
    .rd_role  (rd_role),
    .init_done(init_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bip_throttle_log2 <= diprrip_pkg::THR_RESET;
    end else if (cfg_we) begin
      bip_throttle_log2 <= cfg_wdata;
    end
  end

  // Row unit for victim search: find first way at max, and the row with every way aged by one.
  always_comb begin
    found     = 1'b0;
    first_way = '0;
    for (int w = 0; w < diprrip_pkg::NUM_WAYS; w++) begin
      row_aged[w*RRPV_W +: RRPV_W] = row[w*RRPV_W +: RRPV_W] + 1'b1;
      if (!found && row[w*RRPV_W +: RRPV_W] == diprrip_pkg::RRPV_TOP) begin
        found     = 1'b1;
        first_way = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= diprrip_pkg::ST_IDLE;
      policy_selector <= diprrip_pkg::SEL_MID;
      access_count    <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state           <= state_next;
      policy_selector <= policy_selector_next;
      access_count    <= access_count_next;
      m_tvalid        <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_r_next;
    set_r   <= set_r_next;
    way_r   <= way_r_next;
    hit_r   <= hit_r_next;
    role_r  <= role_r_next;
    row     <= row_next;
    aged    <= aged_next;
    victim  <= victim_next;
    ins     <= ins_next;
    m_tdata <= m_tdata_next;
  end

  assign s_tready = (state == diprrip_pkg::ST_IDLE) && init_done;

  always_comb begin
    logic [ACC_W-1:0]               acc_inc;
    logic [diprrip_pkg::THR_W-1:0]  thr_sat;
    logic [ACC_W:0]                 one_sh;
    logic [ACC_W:0]                 mask_w;
    logic [RRPV_W-1:0]              bip_ins;
    logic [RRPV_W-1:0]              upd_ins;

    state_next           = state;
    op_r_next            = op_r;
    set_r_next           = set_r;
    way_r_next           = way_r;
    hit_r_next           = hit_r;
    role_r_next          = role_r;
    row_next             = row;
    aged_next            = aged;
    victim_next          = victim;
    ins_next             = ins;
    policy_selector_next = policy_selector;
    access_count_next    = access_count;
    m_tvalid_next        = m_tvalid;
    m_tdata_next         = m_tdata;
    rd                   = '0;
    wr                   = '0;

    acc_inc = access_count + 1'b1;
    thr_sat = (bip_throttle_log2 > diprrip_pkg::THR_SAT) ?
              diprrip_pkg::THR_SAT : bip_throttle_log2;
    one_sh  = (ACC_W+1)'(1) << thr_sat;
    mask_w  = one_sh - 1'b1;
    bip_ins = ((acc_inc & mask_w[ACC_W-1:0]) == '0) ? '0 : diprrip_pkg::RRPV_TOP;

    upd_ins = '0;
    if (!hit_r) begin
      case (role_r)
        diprrip_pkg::ROLE_LIP: upd_ins = '0;
        diprrip_pkg::ROLE_BIP: upd_ins = bip_ins;
        default: begin
          upd_ins = (policy_selector >= diprrip_pkg::SEL_MID) ? bip_ins : '0;
        end
      endcase
    end

    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end

    case (state)
      diprrip_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          op_r_next  = diprrip_pkg::op_t'(s_tuser);
          set_r_next = s_tdata[SET_W-1:0];
          way_r_next = s_tdata[SET_W +: WAY_W];
          hit_r_next = s_tdata[SET_W + WAY_W];
          aged_next  = 1'b0;
          rd.en      = 1'b1;
          rd.addr    = s_tdata[SET_W-1:0];
          state_next = diprrip_pkg::ST_LOAD;
        end
      end
      diprrip_pkg::ST_LOAD: begin
        row_next    = rd_row;
        role_r_next = rd_role;
        state_next  = diprrip_pkg::ST_WORK;
      end
      diprrip_pkg::ST_WORK: begin
        if (op_r == diprrip_pkg::OP_VICTIM) begin
          if (found) begin
            victim_next = first_way;
            ins_next    = '0;
            state_next  = aged ? diprrip_pkg::ST_WRITE : diprrip_pkg::ST_DONE;
          end else begin
            row_next  = row_aged;
            aged_next = 1'b1;
          end
        end else begin
          access_count_next = acc_inc;
          victim_next       = '0;
          ins_next          = upd_ins;
          row_next[way_r*RRPV_W +: RRPV_W] = upd_ins;
          if (!hit_r) begin
            if (role_r == diprrip_pkg::ROLE_LIP &&
                policy_selector != diprrip_pkg::SEL_MAX) begin
              policy_selector_next = policy_selector + 1'b1;
            end else if (role_r == diprrip_pkg::ROLE_BIP && policy_selector != '0) begin
              policy_selector_next = policy_selector - 1'b1;
            end
          end
          state_next = diprrip_pkg::ST_WRITE;
        end
      end
      diprrip_pkg::ST_WRITE: begin
        wr.en      = 1'b1;
        wr.addr    = set_r;
        wr.row     = row;
        state_next = diprrip_pkg::ST_DONE;
      end
      diprrip_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {policy_selector, ins, victim};
          state_next    = diprrip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = diprrip_pkg::ST_IDLE;
      end
    endcase
  end

  `DIPRRIP_ASSERT(a_ready_after_init, s_tready |-> init_done, "item taken during memory sweep")
  `DIPRRIP_ASSERT(a_wr_after_init, wr.en |-> init_done, "row written during memory sweep")
  `DIPRRIP_ASSERT_NEXT(a_victim_keeps_sel, (state == diprrip_pkg::ST_WORK && op_r == diprrip_pkg::OP_VICTIM), $stable(policy_selector), "selector moved on victim search")
  `DIPRRIP_ASSERT_NEXT(a_age_loops, (state == diprrip_pkg::ST_WORK && op_r == diprrip_pkg::OP_VICTIM && !found), (state == diprrip_pkg::ST_WORK && aged), "aging round lost")
  `DIPRRIP_ASSERT(a_out_from_done, $rose(m_tvalid) |-> $past(state == diprrip_pkg::ST_DONE), "result raised outside done state")

endmodule

/* dv/tb.sv */
module tb;
  import diprrip_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOT_COUNT    = 6;

  // same bit order as m_tdata: victim_way lowest
  typedef struct packed {
    logic [SEL_W-1:0]  sel;
    logic [RRPV_W-1:0] ins;
    logic [WAY_W-1:0]  victim;
  } access_result_t;

  class rrip_scoreboard;
    logic [RRPV_W-1:0] rrpv [NUM_SETS][NUM_WAYS];
    role_t             role [NUM_SETS];
    logic [SEL_W-1:0]  selector;
    logic [ACC_W-1:0]  accesses;
    logic [THR_W-1:0]  throttle;
    access_result_t    pending[$];
    logic [WAY_W-1:0]  last_victim;
    int                errors;
    int                checked;
    int                rounds_seen[4];
    int                sel_lo;
    int                sel_hi;

    function new();
      int a;
      int b;
      for (int s = 0; s < NUM_SETS; s++) begin
        role[s] = ROLE_FOLLOW;
        for (int w = 0; w < NUM_WAYS; w++) rrpv[s][w] = RRPV_TOP;
      end
      // first role wins when the two placements collide
      for (int i = 0; i < LEADER_COUNT_DEF; i++) begin
        a = (i * LIP_MULT) % NUM_SETS;
        b = (i * BIP_MULT + BIP_OFFSET) % NUM_SETS;
        if (role[a] == ROLE_FOLLOW) role[a] = ROLE_LIP;
        if (role[b] == ROLE_FOLLOW) role[b] = ROLE_BIP;
      end
      selector = SEL_MID;
      accesses = '0;
      throttle = THR_RESET;
      errors = 0;
      checked = 0;
      sel_lo = int'(SEL_MID);
      sel_hi = int'(SEL_MID);
      last_victim = '0;
      for (int i = 0; i < 4; i++) rounds_seen[i] = 0;
    endfunction

    function logic [WAY_W-1:0] find_victim(logic [SET_W-1:0] s);
      logic [RRPV_W-1:0] top;
      logic [RRPV_W-1:0] lift;
      logic [WAY_W-1:0]  way;
      bit                found;
      top = '0;
      for (int w = 0; w < NUM_WAYS; w++) if (rrpv[s][w] > top) top = rrpv[s][w];
      lift = RRPV_TOP - top;
      rounds_seen[lift]++;
      if (lift != 0) for (int w = 0; w < NUM_WAYS; w++) rrpv[s][w] += lift;
      way = '0;
      found = 0;
      for (int w = 0; w < NUM_WAYS; w++)
        if (!found && rrpv[s][w] == RRPV_TOP) begin
          way = WAY_W'(w);
          found = 1;
        end
      return way;
    endfunction

    // near insertion once per 2^throttle accesses (throttle capped at ACC_W), distant otherwise
    function logic [RRPV_W-1:0] bip_fill();
      int t;
      t = int'((throttle > THR_SAT) ? THR_SAT : throttle);
      return ((int'(accesses) & ((1 << t) - 1)) == 0) ? '0 : RRPV_TOP;
    endfunction

    function void note_access(op_t op, logic [SET_W-1:0] s, logic [WAY_W-1:0] way,
                              logic hit);
      access_result_t r;
      r = '0;
      if (op == OP_VICTIM) begin
        r.victim = find_victim(s);
        last_victim = r.victim;
      end else begin
        accesses++;
        if (!hit) begin
          case (role[s])
            ROLE_LIP: begin
              r.ins = '0;
              if (selector != SEL_MAX) selector++;
            end
            ROLE_BIP: begin
              r.ins = bip_fill();
              if (selector != '0) selector--;
            end
            default: begin
              r.ins = (selector >= SEL_MID) ? bip_fill() : '0;
            end
          endcase
        end
        rrpv[s][way] = r.ins;
      end
      r.sel = selector;
      if (int'(selector) < sel_lo) sel_lo = int'(selector);
      if (int'(selector) > sel_hi) sel_hi = int'(selector);
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= 50)
        $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
                 what, checked, got, want);
    endtask

    task check_result(logic [OUT_W-1:0] data);
      access_result_t got;
      access_result_t want;
      got = data;
      if (pending.size() == 0) begin
        report("unexpected result", int'(data), 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.victim != want.victim)
        report("victim_way", int'(got.victim), int'(want.victim));
      if (got.ins != want.ins) report("inserted_value", int'(got.ins), int'(want.ins));
      if (got.sel != want.sel) report("selector_value", int'(got.sel), int'(want.sel));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [THR_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;

  rrip_scoreboard        sb;
  int                    tx_idle_pct = 10;
  int                    rx_idle_pct = 58;
  int                    items_sent = 0;
  int                    cycles = 0;
  logic [SET_W-1:0]      hot_sets[HOT_COUNT];

  dip_rrip_replacement dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_access(op_t op, logic [SET_W-1:0] s, logic [WAY_W-1:0] way,
                             logic hit);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {hit, way, s};
    do @(posedge clk); while (!s_tready);
    sb.note_access(op, s, way, hit);
    items_sent++;
    sender_gap();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_throttle(logic [THR_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.throttle = value;
  endtask

  function automatic logic [SET_W-1:0] pick_set(role_t r);
    logic [SET_W-1:0] s;
    do s = SET_W'($urandom_range(NUM_SETS - 1)); while (sb.role[s] != r);
    return s;
  endfunction

  task automatic run_directed();
    // set 0 leads for LIP, set BIP_OFFSET leads for BIP, 1 and 100 follow
    send_access(OP_VICTIM, '0, '0, 1'b0);
    send_access(OP_UPDATE, '0, '0, 1'b0);
    send_access(OP_VICTIM, '0, WAY_W'(NUM_WAYS - 1), 1'b1);
    send_access(OP_UPDATE, SET_W'(NUM_SETS - 1), WAY_W'(NUM_WAYS - 1), 1'b1);
    send_access(OP_UPDATE, SET_W'(BIP_OFFSET), WAY_W'(NUM_WAYS - 1), 1'b0);
    send_access(OP_UPDATE, SET_W'(1), WAY_W'(7), 1'b0);
    send_access(OP_UPDATE, SET_W'(NUM_SETS - 1), '0, 1'b0);
    // every way near: the search has to age the row three times
    for (int w = 0; w < NUM_WAYS; w++) send_access(OP_UPDATE, SET_W'(100), WAY_W'(w), 1'b1);
    send_access(OP_VICTIM, SET_W'(100), '0, 1'b0);
  endtask

  task automatic run_mixed(int n);
    int               start;
    int               pick;
    bit               paused;
    logic [SET_W-1:0] s;
    start = items_sent;
    paused = 0;
    while (items_sent - start < n) begin
      if (!paused && items_sent - start >= n / 2) begin
        drain();
        paused = 1;
      end
      pick = $urandom_range(99);
      s = hot_sets[$urandom_range(HOT_COUNT - 1)];
      if (pick < 70) begin
        // up to four hits, then a victim search and a fill of the chosen way
        repeat ($urandom_range(4))
          send_access(OP_UPDATE, s, WAY_W'($urandom_range(NUM_WAYS - 1)), 1'b1);
        send_access(OP_VICTIM, s, WAY_W'($urandom_range(NUM_WAYS - 1)),
                    1'($urandom_range(1)));
        send_access(OP_UPDATE, s, sb.last_victim, 1'b0);
      end else if (pick < 85) begin
        send_access(OP_UPDATE, s, WAY_W'($urandom_range(NUM_WAYS - 1)), 1'b0);
      end else begin
        send_access(op_t'($urandom_range(1)), SET_W'($urandom_range(NUM_SETS - 1)),
                    WAY_W'($urandom_range(NUM_WAYS - 1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // leader misses of one kind drive the selector into saturation
  task automatic run_sweep(int n, role_t r);
    repeat (n) begin
      if ($urandom_range(19) == 0)
        send_access(OP_VICTIM, pick_set(r), WAY_W'($urandom_range(NUM_WAYS - 1)),
                    1'($urandom_range(1)));
      else
        send_access(OP_UPDATE, pick_set(r), WAY_W'($urandom_range(NUM_WAYS - 1)), 1'b0);
    end
  endtask

  initial begin
    sb = new();
    hot_sets[0] = pick_set(ROLE_LIP);
    hot_sets[1] = pick_set(ROLE_LIP);
    hot_sets[2] = pick_set(ROLE_BIP);
    hot_sets[3] = pick_set(ROLE_BIP);
    hot_sets[4] = pick_set(ROLE_FOLLOW);
    hot_sets[5] = pick_set(ROLE_FOLLOW);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_throttle(4'd0);
    run_directed();

    set_throttle(4'd15);
    run_mixed(70);

    tx_idle_pct = 58;
    rx_idle_pct = 10;
    set_throttle(4'd3);
    run_mixed(70);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_throttle(4'd1);
    run_sweep(560, ROLE_BIP);

    drain();
    $display("tb: %0d items, %0d results checked, selector ranged %0d to %0d",
             items_sent, sb.checked, sb.sel_lo, sb.sel_hi);
    $display("tb: victim searches by aging rounds 0/1/2/3: %0d/%0d/%0d/%0d",
             sb.rounds_seen[0], sb.rounds_seen[1], sb.rounds_seen[2], sb.rounds_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
